// ===== design/smgr_pkg.sv =====
// ----------------------------------------------------------------------------
// smgr_pkg
// Shared types and constants for the stereo mixer with linear gain ramp.
// ----------------------------------------------------------------------------
`default_nettype none

package smgr_pkg;

   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 18;
   localparam int DELTA_W  = 19;
   localparam int COUNT_W  = 32;

   localparam logic [GAIN_W-1:0] GAIN_ONE = 18'd65536;
   localparam logic [GAIN_W-1:0] GAIN_MAX = 18'd131072;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_POS_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_NEG_MAX = 16'sh8000;

   typedef logic [GAIN_W-1:0] csr_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] src_left;
      logic signed [SAMPLE_W-1:0] src_right;
      logic                       last_source;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_left;
      logic signed [SAMPLE_W-1:0] out_right;
      logic                       left_clipped;
      logic                       right_clipped;
      logic [COUNT_W-1:0]         clip_total;
      logic                       end_of_block;
      logic [COUNT_W-1:0]         head_position;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RAMP,
      ST_GAIN,
      ST_LEFT,
      ST_RIGHT,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      MUL_RAMP,
      MUL_LEFT,
      MUL_RIGHT
   } mul_sel_type;

   typedef struct packed {
      logic        take;
      logic        close;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        gain_load;
      logic        left_load;
      logic        commit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== design/smgr_chan_if.sv =====
// ----------------------------------------------------------------------------
// smgr_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface smgr_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/smgr_ctrl.sv =====
// ----------------------------------------------------------------------------
// smgr_ctrl
// Sequencer: accepts source beats, then steps the shared multiplier through
// ramp, left and right products and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module smgr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_last,
   input  wire smgr_pkg::status_type status,
   output logic                      req_ready,
   output smgr_pkg::cmd_type         cmd
);

   smgr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smgr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.mul_sel   = smgr_pkg::MUL_RAMP;
      case (state_ff)
         smgr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (req_last) begin
                  cmd.close = 1'b1;
                  state_in  = smgr_pkg::ST_RAMP;
               end
            end
         end
         smgr_pkg::ST_RAMP: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = smgr_pkg::MUL_RAMP;
            state_in    = smgr_pkg::ST_GAIN;
         end
         smgr_pkg::ST_GAIN: begin
            cmd.gain_load = 1'b1;
            state_in      = smgr_pkg::ST_LEFT;
         end
         smgr_pkg::ST_LEFT: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = smgr_pkg::MUL_LEFT;
            state_in    = smgr_pkg::ST_RIGHT;
         end
         smgr_pkg::ST_RIGHT: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = smgr_pkg::MUL_RIGHT;
            cmd.left_load = 1'b1;
            state_in      = smgr_pkg::ST_OUT;
         end
         smgr_pkg::ST_OUT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = smgr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = smgr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/smgr_dpath.sv =====
// ----------------------------------------------------------------------------
// smgr_dpath
// Mix accumulators, gain ramp, shared multiplier, saturation, counters and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module smgr_dpath #(
   parameter int BLOCK_SAMPLES = 512,
   parameter int MAX_SOURCES   = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire smgr_pkg::cmd_type    cmd,
   output smgr_pkg::status_type      status,
   input  wire smgr_pkg::req_type    req_data,
   input  wire logic                 csr_write,
   input  wire smgr_pkg::csr_type    csr_data,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output smgr_pkg::rsp_type         rsp_data
);

   localparam int IDX_W  = $clog2(BLOCK_SAMPLES);
   localparam int CNT_W  = $clog2(MAX_SOURCES + 1);
   localparam int ACC_W  = smgr_pkg::SAMPLE_W + $clog2(MAX_SOURCES);
   localparam int OPA_W  = (ACC_W > smgr_pkg::DELTA_W) ? ACC_W : smgr_pkg::DELTA_W;
   localparam int PROD_W = OPA_W + smgr_pkg::DELTA_W;
   localparam logic signed [PROD_W-1:0] PROD_ONE = PROD_W'(64'sd2147483648);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BLOCK_SAMPLES - 1);
   localparam logic [CNT_W-1:0] SRC_MAX  = CNT_W'(MAX_SOURCES);
   localparam logic [smgr_pkg::COUNT_W-1:0] BLOCK_STEP =
      smgr_pkg::COUNT_W'(BLOCK_SAMPLES);

   logic [smgr_pkg::GAIN_W-1:0]          target_ff;
   logic [smgr_pkg::GAIN_W-1:0]          block_target_ff, block_target_in;
   logic [smgr_pkg::GAIN_W-1:0]          prev_gain_ff;
   logic [IDX_W-1:0]                     sample_index_ff;
   logic signed [ACC_W-1:0]              acc_left_ff, acc_right_ff;
   logic [CNT_W-1:0]                     src_count_ff;
   logic [smgr_pkg::COUNT_W-1:0]         clip_count_ff;
   logic [smgr_pkg::COUNT_W-1:0]         play_head_ff;
   logic signed [smgr_pkg::DELTA_W-1:0]  delta_ff, delta_in;
   logic signed [PROD_W-1:0]             prod_ff, prod_in;
   logic [smgr_pkg::GAIN_W-1:0]          gain_ff;
   logic signed [smgr_pkg::SAMPLE_W-1:0] left_ff;
   logic                                 left_clip_ff;
   logic                                 rsp_valid_ff;
   smgr_pkg::rsp_type                    rsp_data_ff, rsp_data_in;

   logic [smgr_pkg::GAIN_W-1:0]          target_clamped;
   logic signed [OPA_W-1:0]              mul_a;
   logic signed [smgr_pkg::DELTA_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]             gain_sum;
   logic                                 sat_hi, sat_lo, sat_clip;
   logic signed [smgr_pkg::SAMPLE_W-1:0] sat_value;
   logic                                 last_sample;

   // Target latch for the block, taken on its first sample.
   assign target_clamped = (target_ff > smgr_pkg::GAIN_MAX) ? smgr_pkg::GAIN_MAX : target_ff;

   always_comb begin
      block_target_in = (sample_index_ff == '0) ? target_clamped : block_target_ff;
      delta_in = $signed({1'b0, block_target_in}) - $signed({1'b0, prev_gain_ff});
   end

   // Shared multiplier.
   always_comb begin
      case (cmd.mul_sel)
         smgr_pkg::MUL_RAMP: begin
            mul_a = OPA_W'(delta_ff);
            mul_b = $signed(smgr_pkg::DELTA_W'(sample_index_ff));
         end
         smgr_pkg::MUL_LEFT: begin
            mul_a = OPA_W'(acc_left_ff);
            mul_b = $signed({1'b0, gain_ff});
         end
         smgr_pkg::MUL_RIGHT: begin
            mul_a = OPA_W'(acc_right_ff);
            mul_b = $signed({1'b0, gain_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   assign gain_sum = PROD_W'($signed({1'b0, prev_gain_ff})) + (prod_ff >>> IDX_W);

   // Saturate the registered product to Q1.15.
   always_comb begin
      sat_hi   = (prod_ff >= PROD_ONE);
      sat_lo   = (prod_ff < -PROD_ONE);
      sat_clip = (prod_ff > PROD_ONE) || sat_lo;
      if (sat_hi) begin
         sat_value = smgr_pkg::SAMPLE_POS_MAX;
      end else if (sat_lo) begin
         sat_value = smgr_pkg::SAMPLE_NEG_MAX;
      end else begin
         sat_value = prod_ff[31:16];
      end
   end

   assign last_sample = (sample_index_ff == IDX_LAST);

   always_comb begin
      rsp_data_in.out_left      = left_ff;
      rsp_data_in.out_right     = sat_value;
      rsp_data_in.left_clipped  = left_clip_ff;
      rsp_data_in.right_clipped = sat_clip;
      rsp_data_in.clip_total    = clip_count_ff
                                + smgr_pkg::COUNT_W'(left_clip_ff)
                                + smgr_pkg::COUNT_W'(sat_clip);
      rsp_data_in.end_of_block  = last_sample;
      rsp_data_in.head_position = play_head_ff + BLOCK_STEP;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff       <= smgr_pkg::GAIN_ONE;
         block_target_ff <= smgr_pkg::GAIN_ONE;
         prev_gain_ff    <= smgr_pkg::GAIN_ONE;
         sample_index_ff <= '0;
         acc_left_ff     <= '0;
         acc_right_ff    <= '0;
         src_count_ff    <= '0;
         clip_count_ff   <= '0;
         play_head_ff    <= BLOCK_STEP;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            target_ff <= csr_data;
         end
         if (cmd.take && (src_count_ff < SRC_MAX)) begin
            acc_left_ff  <= acc_left_ff + ACC_W'(req_data.src_left);
            acc_right_ff <= acc_right_ff + ACC_W'(req_data.src_right);
            src_count_ff <= src_count_ff + CNT_W'(1);
         end
         if (cmd.close) begin
            block_target_ff <= block_target_in;
         end
         if (cmd.commit) begin
            acc_left_ff   <= '0;
            acc_right_ff  <= '0;
            src_count_ff  <= '0;
            clip_count_ff <= rsp_data_in.clip_total;
            rsp_valid_ff  <= 1'b1;
            if (last_sample) begin
               prev_gain_ff    <= block_target_ff;
               play_head_ff    <= rsp_data_in.head_position;
               sample_index_ff <= '0;
            end else begin
               sample_index_ff <= sample_index_ff + IDX_W'(1);
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      if (cmd.close) begin
         delta_ff <= delta_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.gain_load) begin
         gain_ff <= gain_sum[smgr_pkg::GAIN_W-1:0];
      end
      if (cmd.left_load) begin
         left_ff      <= sat_value;
         left_clip_ff <= sat_clip;
      end
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

`default_nettype wire

// ===== design/stereo_mixer_gain_ramp_core.sv =====
// ----------------------------------------------------------------------------
// stereo_mixer_gain_ramp_core
// Sums stereo source beats into output samples and scales them by a master
// gain that ramps linearly across each block, with Q1.15 saturation.
//
//   channel   dir   payload              beat
//   req_chan  in    src_left/right/last  one source frame
//   rsp_chan  out   mixed sample + stats one output sample
//   csr_chan  in    target_gain          one register write
//
// A source beat without last_source is only accumulated. A closing beat is
// accumulated and then steps through ramp, gain add, left, right and hand-over
// to the output register; its result is registered valid at the hand-over.
// The next beat is accepted while a result waits in the output register;
// the hand-over holds, and input with it, while that register is still full.
// Reset is synchronous; it sets the gain to one and the head to one block.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_mixer_gain_ramp_core #(
   parameter int BLOCK_SAMPLES = 512,
   parameter int MAX_SOURCES   = 8
) (
   input  wire logic   clock,
   input  wire logic   reset,
   smgr_chan_if.sink   req_chan,
   smgr_chan_if.source rsp_chan,
   smgr_chan_if.sink   csr_chan
);

   smgr_pkg::cmd_type    cmd;
   smgr_pkg::status_type status;
   logic                 req_ready;

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   smgr_ctrl u_smgr_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.payload.last_source),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   smgr_dpath #(
      .BLOCK_SAMPLES (BLOCK_SAMPLES),
      .MAX_SOURCES   (MAX_SOURCES)
   ) u_smgr_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_chan.payload),
      .csr_write (csr_chan.valid),
      .csr_data  (csr_chan.payload),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_data  (rsp_chan.payload)
   );

endmodule

`default_nettype wire

// ===== design/smgr_checker.sv =====
// ----------------------------------------------------------------------------
// smgr_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module smgr_checker #(
   parameter int BLOCK_SAMPLES = 512
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire smgr_pkg::rsp_type rsp_payload
);

   localparam logic [smgr_pkg::COUNT_W-1:0] BLOCK_STEP =
      smgr_pkg::COUNT_W'(BLOCK_SAMPLES);

   logic                         seen_ff;
   logic [smgr_pkg::COUNT_W-1:0] prev_clip_ff;
   logic [smgr_pkg::COUNT_W-1:0] prev_head_ff;
   logic                         prev_eob_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         prev_clip_ff <= rsp_payload.clip_total;
         prev_head_ff <= rsp_payload.head_position;
         prev_eob_ff  <= rsp_payload.end_of_block;
      end
   end

   a_reset_clears_valid: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold_stalled_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat changed");

   a_clip_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.left_clipped |->
         rsp_payload.out_left == smgr_pkg::SAMPLE_POS_MAX ||
         rsp_payload.out_left == smgr_pkg::SAMPLE_NEG_MAX)
      else $error("clipped left sample not saturated");

   a_clip_total_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_ff |->
         rsp_payload.clip_total == prev_clip_ff
            + smgr_pkg::COUNT_W'(rsp_payload.left_clipped)
            + smgr_pkg::COUNT_W'(rsp_payload.right_clipped))
      else $error("clip total does not follow clip flags");

   a_head_advances_per_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_ff |->
         rsp_payload.head_position ==
            (prev_eob_ff ? prev_head_ff + BLOCK_STEP : prev_head_ff))
      else $error("head position moved outside block end");

endmodule

bind stereo_mixer_gain_ramp_core smgr_checker #(
   .BLOCK_SAMPLES (BLOCK_SAMPLES)
) u_smgr_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

`default_nettype wire

// ===== sim/smgr_mix_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smgr_mix_checker
// Watches the source, sample and register channels of the stereo mixer.
// Keeps its own mix, ramp and saturation state, predicts each output sample
// from the source beats it sees taken, and compares each sample beat field by
// field with the oldest prediction. Counts mismatches for the testbench top.
// ----------------------------------------------------------------------------
module smgr_mix_checker #(
   parameter int BLOCK_SAMPLES = 512,
   parameter int MAX_SOURCES   = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  smgr_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  smgr_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  smgr_pkg::csr_type csr_payload,
   output int                mismatch_count,
   output int                samples_pending
);

   smgr_pkg::csr_type           target_reg;
   logic [smgr_pkg::GAIN_W-1:0] ramp_from;
   logic [smgr_pkg::GAIN_W-1:0] ramp_to;
   int                          sample_index;
   int                          src_count;
   longint                      acc_left;
   longint                      acc_right;
   logic [31:0]                 clip_count;
   logic [31:0]                 play_head;
   smgr_pkg::rsp_type           expected_samples[$];

   function automatic logic signed [smgr_pkg::SAMPLE_W-1:0] scale_channel(
      input longint mix, input logic [smgr_pkg::GAIN_W-1:0] gain, output logic clipped);
      longint product;
      longint unity;
      unity   = 64'sd2147483648;
      product = mix * longint'(gain);
      clipped = (product > unity) || (product < -unity);
      if (product >= unity) return smgr_pkg::SAMPLE_POS_MAX;
      if (product < -unity) return smgr_pkg::SAMPLE_NEG_MAX;
      return smgr_pkg::SAMPLE_W'(product >>> 16);
   endfunction

   task automatic mix_source(input smgr_pkg::req_type beat);
      smgr_pkg::rsp_type sample;
      longint            ramp_step;
      longint            ramp_part;
      longint            gain_now;
      logic              left_clip;
      logic              right_clip;
      if (src_count < MAX_SOURCES) begin
         acc_left  += longint'(beat.src_left);
         acc_right += longint'(beat.src_right);
         src_count++;
      end
      if (!beat.last_source) return;
      if (sample_index == 0) begin
         ramp_to = (target_reg > smgr_pkg::GAIN_MAX) ? smgr_pkg::GAIN_MAX : target_reg;
      end
      ramp_step = (longint'(ramp_to) - longint'(ramp_from)) * sample_index;
      ramp_part = ramp_step / BLOCK_SAMPLES;
      if ((ramp_step % BLOCK_SAMPLES) != 0 && ramp_step < 0) ramp_part -= 1;
      gain_now = longint'(ramp_from) + ramp_part;
      sample.out_left      = scale_channel(acc_left, gain_now[smgr_pkg::GAIN_W-1:0],
                                           left_clip);
      sample.out_right     = scale_channel(acc_right, gain_now[smgr_pkg::GAIN_W-1:0],
                                           right_clip);
      sample.left_clipped  = left_clip;
      sample.right_clipped = right_clip;
      clip_count           = clip_count + 32'(left_clip) + 32'(right_clip);
      sample.clip_total    = clip_count;
      sample.end_of_block  = (sample_index >= BLOCK_SAMPLES - 1);
      sample.head_position = 32'(play_head + BLOCK_SAMPLES);
      expected_samples     = {expected_samples, sample};
      acc_left  = 0;
      acc_right = 0;
      src_count = 0;
      if (sample.end_of_block) begin
         ramp_from    = ramp_to;
         play_head    = 32'(play_head + BLOCK_SAMPLES);
         sample_index = 0;
      end else begin
         sample_index++;
      end
   endtask

   task automatic check_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      smgr_pkg::rsp_type want;
      if (reset) begin
         target_reg     = smgr_pkg::GAIN_ONE;
         ramp_from      = smgr_pkg::GAIN_ONE;
         ramp_to        = smgr_pkg::GAIN_ONE;
         sample_index   = 0;
         src_count      = 0;
         acc_left       = 0;
         acc_right      = 0;
         clip_count     = '0;
         play_head      = BLOCK_SAMPLES;
         mismatch_count = 0;
         expected_samples.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: sample beat with none expected, got %p", $time, rsp_payload);
               mismatch_count++;
            end else begin
               want = expected_samples.pop_front();
               check_field("out_left", want.out_left, rsp_payload.out_left);
               check_field("out_right", want.out_right, rsp_payload.out_right);
               check_field("left_clipped", want.left_clipped, rsp_payload.left_clipped);
               check_field("right_clipped", want.right_clipped, rsp_payload.right_clipped);
               check_field("clip_total", want.clip_total, rsp_payload.clip_total);
               check_field("end_of_block", want.end_of_block, rsp_payload.end_of_block);
               check_field("head_position", want.head_position,
                           rsp_payload.head_position);
            end
         end
         if (csr_valid && csr_ready) target_reg = csr_payload;
         if (req_valid && req_ready) mix_source(req_payload);
      end
      samples_pending <= expected_samples.size();
   end

endmodule

// ===== sim/tb_stereo_mixer_gain_ramp_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_mixer_gain_ramp_core
// Drives source beats, target gain writes and sample back-pressure into the
// stereo mixer: a directed set of edge mixes at unity gain, then phases of
// random mixes under a range of targets with random gaps on both sides.
// A checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_stereo_mixer_gain_ramp_core;

   localparam int BLOCK_SAMPLES = 512;
   localparam int MAX_SOURCES   = 8;
   localparam int ITEM_TARGET   = 1750;
   localparam int IDLE_CYCLES   = 16;
   localparam int STALL_LIMIT   = 1000;

   logic clock;
   logic reset;
   logic feed_burst  = 1'b0;
   logic drain_burst = 1'b0;
   int   mismatch_count;
   int   samples_pending;
   int   stall_cycles = 0;
   int   sources_sent = 0;

   smgr_chan_if #(.payload_type(smgr_pkg::req_type)) req_chan ();
   smgr_chan_if #(.payload_type(smgr_pkg::rsp_type)) rsp_chan ();
   smgr_chan_if #(.payload_type(smgr_pkg::csr_type)) csr_chan ();

   stereo_mixer_gain_ramp_core #(
      .BLOCK_SAMPLES(BLOCK_SAMPLES),
      .MAX_SOURCES  (MAX_SOURCES)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   smgr_mix_checker #(
      .BLOCK_SAMPLES(BLOCK_SAMPLES),
      .MAX_SOURCES  (MAX_SOURCES)
   ) mix_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_payload    (req_chan.payload),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_payload    (rsp_chan.payload),
      .csr_valid      (csr_chan.valid),
      .csr_ready      (csr_chan.ready),
      .csr_payload    (csr_chan.payload),
      .mismatch_count (mismatch_count),
      .samples_pending(samples_pending)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      forever begin
         gap = drain_burst ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         @(negedge clock);
      end
   end

   function automatic logic signed [smgr_pkg::SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0:       return smgr_pkg::SAMPLE_POS_MAX;
         1:       return smgr_pkg::SAMPLE_NEG_MAX;
         2:       return $urandom_range(0, 1) ? 16'sh0000 : 16'shFFFF;
         3, 4, 5: return smgr_pkg::SAMPLE_W'(int'($urandom_range(0, 8191)) - 4096);
         default: return smgr_pkg::SAMPLE_W'($urandom());
      endcase
   endfunction

   task automatic send_source(input logic signed [smgr_pkg::SAMPLE_W-1:0] left,
                              input logic signed [smgr_pkg::SAMPLE_W-1:0] right,
                              input logic last);
      smgr_pkg::req_type beat;
      int                gap;
      beat.src_left    = left;
      beat.src_right   = right;
      beat.last_source = last;
      gap = feed_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.payload <= beat;
      req_chan.valid   <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic send_mix();
      int pick;
      int sources;
      pick = $urandom_range(0, 99);
      if (pick < 85) sources = 1;
      else if (pick < 97) sources = $urandom_range(2, MAX_SOURCES);
      else sources = $urandom_range(MAX_SOURCES + 1, MAX_SOURCES + 3);
      for (int i = 0; i < sources; i++) begin
         send_source(random_sample(), random_sample(), i == sources - 1);
      end
      sources_sent += (sources > MAX_SOURCES) ? MAX_SOURCES : sources;
   endtask

   // drop valid, drain the outstanding samples, then idle
   task automatic settle();
      req_chan.valid <= 1'b0;
      wait (samples_pending == 0);
      @(negedge clock);
      repeat (IDLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_target(input smgr_pkg::csr_type value);
      csr_chan.payload <= value;
      csr_chan.valid   <= 1'b1;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   initial begin
      smgr_pkg::csr_type targets[6];
      int                phase;
      int                quota;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      csr_chan.valid   = 1'b0;
      csr_chan.payload = smgr_pkg::GAIN_ONE;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_source(smgr_pkg::SAMPLE_POS_MAX, smgr_pkg::SAMPLE_NEG_MAX, 1'b1);
      send_source(16'sd16384, -16'sd16384, 1'b0);
      send_source(16'sd16384, -16'sd16384, 1'b1);
      send_source(smgr_pkg::SAMPLE_POS_MAX, smgr_pkg::SAMPLE_NEG_MAX, 1'b0);
      send_source(smgr_pkg::SAMPLE_POS_MAX, smgr_pkg::SAMPLE_NEG_MAX, 1'b1);
      send_source(16'sd0, 16'sd0, 1'b1);
      send_source(-16'sd1, 16'sd1, 1'b1);
      for (int i = 0; i < MAX_SOURCES; i++) send_source(16'sd4000, -16'sd4000, 1'b0);
      send_source(16'sd30000, -16'sd30000, 1'b1);
      sources_sent = 7 + MAX_SOURCES;
      settle();

      targets[0] = 18'h3FFFF;
      targets[1] = 18'd0;
      targets[2] = smgr_pkg::GAIN_MAX;
      targets[3] = smgr_pkg::GAIN_ONE;
      targets[4] = 18'd32768;
      targets[5] = 18'd98304;
      phase = 0;
      while (sources_sent < ITEM_TARGET) begin
         write_target((phase % 3 == 2)
                         ? smgr_pkg::csr_type'($urandom_range(0, 18'h3FFFF))
                         : targets[phase % 6]);
         feed_burst  = ($urandom_range(0, 3) == 0);
         drain_burst = ($urandom_range(0, 3) == 0);
         quota = $urandom_range(100, 250);
         for (int s = 0; s < quota && sources_sent < ITEM_TARGET; s++) send_mix();
         settle();
         phase++;
      end

      if (mismatch_count == 0 && samples_pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/smgr_pkg.sv
design/smgr_chan_if.sv
design/smgr_ctrl.sv
design/smgr_dpath.sv
design/stereo_mixer_gain_ramp_core.sv
design/smgr_checker.sv
sim/smgr_mix_checker.sv
sim/tb_stereo_mixer_gain_ramp_core.sv
